@@ rtl/bwe_pkg.sv @@
// ----------------------------------------------------------------------------
// bwe_pkg
// Shared constants for the bandwidth window estimator: default window, data
// width, request codes, the selection thresholds and the all-ones value.
// ----------------------------------------------------------------------------
package bwe_pkg;

   localparam int          DEFAULT_WINDOW = 16;
   localparam int          DATA_W         = 32;

   localparam logic        REQ_SAMPLE     = 1'b0;
   localparam logic        REQ_QUERY      = 1'b1;

   localparam logic [31:0] MIN_FOR_STATS  = 32'd5;
   localparam logic [31:0] DEV_LIMIT      = 32'd100000;
   localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

endpackage

@@ rtl/bwe_ring.sv @@
// ----------------------------------------------------------------------------
// bwe_ring
// Sample ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bwe_ring #(
   parameter int WINDOW = bwe_pkg::DEFAULT_WINDOW,
   parameter int IDX_W  = 4
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [bwe_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [bwe_pkg::DATA_W-1:0] rd_data
);

   logic [bwe_pkg::DATA_W-1:0] mem [WINDOW];
   logic [bwe_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bwe_alu.sv @@
// ----------------------------------------------------------------------------
// bwe_alu
// Shared add/subtract unit; carry out doubles as the unsigned a >= b flag.
// ----------------------------------------------------------------------------
module bwe_alu #(
   parameter int WIDTH = 38
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] res,
   output logic             carry
);

   logic [WIDTH-1:0] b_op;

   assign b_op = sub ? ~b : b;
   assign {carry, res} = {1'b0, a} + {1'b0, b_op} + (WIDTH+1)'(sub);

endmodule

@@ rtl/bandwidth_window_estimator.sv @@
// ----------------------------------------------------------------------------
// bandwidth_window_estimator
// Keeps a ring of recent throughput samples and, on a query, derives a
// usable speed from their minimum, mean and summed deviation, under a
// sticky speed cap. Sums, comparisons and the divider share one adder.
//
//   channel   ports                                  handshake
//   request   req_type req_sample_speed              start / busy
//             req_current_bandwidth req_video_delay
//   response  rsp_chosen_speed                       rsp_valid strobe
//
// A sample transfer leaves busy low. A query with N stored samples: N = 0
// goes straight to the clamp step; N < 5 walks the ring once for the
// minimum; otherwise the serial divider (one quotient bit per cycle) forms
// the mean and the ring read port is walked again for the deviation. The
// result shows in the same cycle that busy falls. Synchronous reset clears
// the slot and fill count and sets the cap to all ones; ring contents stay
// undefined until written. The response cannot be stalled.
// ----------------------------------------------------------------------------
module bandwidth_window_estimator #(
   parameter int WINDOW = bwe_pkg::DEFAULT_WINDOW
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_sample_speed,
   input  logic [31:0] req_current_bandwidth,
   input  logic        req_video_delay,
   output logic        rsp_valid,
   output logic [31:0] rsp_chosen_speed
);

   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = bwe_pkg::DATA_W + CNT_W;
   localparam int ALU_W  = SUM_W + 1;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RDNEW   = 4'd1;
   localparam logic [3:0] S_LDNEW   = 4'd2;
   localparam logic [3:0] S_SUM     = 4'd3;
   localparam logic [3:0] S_MIN     = 4'd4;
   localparam logic [3:0] S_DIV     = 4'd5;
   localparam logic [3:0] S_P2RD    = 4'd6;
   localparam logic [3:0] S_ABSA    = 4'd7;
   localparam logic [3:0] S_ABSB    = 4'd8;
   localparam logic [3:0] S_ACC     = 4'd9;
   localparam logic [3:0] S_DEVCMP  = 4'd10;
   localparam logic [3:0] S_MEANCMP = 4'd11;
   localparam logic [3:0] S_CAP     = 4'd12;
   localparam logic [3:0] S_CAPDEC  = 4'd13;
   localparam logic [3:0] S_CLAMP   = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]  filled_ff, filled_in;
   logic [31:0]       cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [IDX_W-1:0]  newest_idx_ff, newest_idx_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              few_ff, few_in;
   logic [31:0]       bw_ff, bw_in;
   logic              lag_ff, lag_in;
   logic [ALU_W-1:0]  limit_ff, limit_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [31:0]       min_ff, min_in;
   logic [31:0]       mean_ff, mean_in;
   logic [31:0]       newest_ff, newest_in;
   logic [31:0]       diff_ff, diff_in;
   logic [31:0]       choice_ff, choice_in;

   logic              accept;
   logic              wr_en;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [31:0]       rd_data;
   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W:0]    rem_sh;

   logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
   logic              alu_sub, alu_ge;

   assign accept  = start && !busy;
   assign wr_en   = accept && (req_type == bwe_pkg::REQ_SAMPLE);
   assign busy    = (state_ff != S_IDLE);
   assign cnt_m1  = filled_ff - 1'b1;
   assign rem_sh  = {rem_ff, quo_ff[SUM_W-1]};

   bwe_ring #(
      .WINDOW (WINDOW),
      .IDX_W  (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (req_sample_speed),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bwe_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .res   (alu_res),
      .carry (alu_ge)
   );

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         S_SUM: begin
            alu_a   = ALU_W'(quo_ff);
            alu_b   = ALU_W'(rd_data);
            alu_sub = 1'b0;
         end
         S_MIN: begin
            alu_a = ALU_W'(rd_data);
            alu_b = ALU_W'(min_ff);
         end
         S_DIV: begin
            alu_a = ALU_W'(rem_sh);
            alu_b = ALU_W'(cnt_ff);
         end
         S_ABSA: begin
            alu_a = ALU_W'(rd_data);
            alu_b = ALU_W'(mean_ff);
         end
         S_ABSB: begin
            alu_a = ALU_W'(mean_ff);
            alu_b = ALU_W'(rd_data);
         end
         S_ACC: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = ALU_W'(diff_ff);
            alu_sub = 1'b0;
         end
         S_DEVCMP: begin
            alu_a = ALU_W'(acc_ff);
            alu_b = limit_ff;
         end
         S_MEANCMP: begin
            alu_a = ALU_W'(mean_ff);
            alu_b = ALU_W'(newest_ff);
         end
         S_CAP: begin
            alu_a = ALU_W'(newest_ff);
            alu_b = ALU_W'(bw_ff);
         end
         S_CAPDEC: begin
            alu_a = ALU_W'(bw_ff);
            alu_b = ALU_W'(1'b1);
         end
         S_CLAMP: begin
            alu_a = ALU_W'(choice_ff);
            alu_b = ALU_W'(cap_ff);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      filled_in     = filled_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      newest_idx_in = newest_idx_ff;
      idx_in        = idx_ff;
      few_in        = few_ff;
      bw_in         = bw_ff;
      lag_in        = lag_ff;
      limit_in      = limit_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      min_in        = min_ff;
      mean_in       = mean_ff;
      newest_in     = newest_ff;
      diff_in       = diff_ff;
      choice_in     = choice_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (wr_en) begin
               slot_in = (slot_ff == IDX_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               if (filled_ff != CNT_W'(WINDOW)) begin
                  filled_in = filled_ff + 1'b1;
               end
            end else if (accept) begin
               cnt_in        = filled_ff;
               last_in       = cnt_m1[IDX_W-1:0];
               newest_idx_in = (slot_ff == '0) ? cnt_m1[IDX_W-1:0] : slot_ff - 1'b1;
               idx_in        = '0;
               few_in        = (32'(filled_ff) < bwe_pkg::MIN_FOR_STATS);
               bw_in         = req_current_bandwidth;
               lag_in        = req_video_delay;
               limit_in      = ALU_W'(bwe_pkg::DEV_LIMIT * 32'(filled_ff));
               quo_in        = '0;
               acc_in        = '0;
               min_in        = bwe_pkg::ALL_ONES;
               choice_in     = bwe_pkg::ALL_ONES;
               state_in      = (filled_ff == '0) ? S_CLAMP : S_RDNEW;
            end
         end
         S_RDNEW: begin
            rd_en    = 1'b1;
            rd_addr  = newest_idx_ff;
            state_in = S_LDNEW;
         end
         S_LDNEW: begin
            newest_in = rd_data;
            rd_en     = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            quo_in   = alu_res[SUM_W-1:0];
            state_in = S_MIN;
         end
         S_MIN: begin
            if (!alu_ge) begin
               min_in = rd_data;
            end
            if (idx_ff == last_ff) begin
               if (few_ff) begin
                  choice_in = alu_ge ? min_ff : rd_data;
                  state_in  = S_CAP;
               end else begin
                  rem_in   = '0;
                  step_in  = STEP_W'(SUM_W - 1);
                  state_in = S_DIV;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = idx_ff + 1'b1;
               state_in = S_SUM;
            end
         end
         S_DIV: begin
            rem_in  = alu_ge ? alu_res[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], alu_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_P2RD;
            end
         end
         S_P2RD: begin
            mean_in  = quo_ff[31:0];
            idx_in   = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_ABSA;
         end
         S_ABSA: begin
            diff_in  = alu_res[31:0];
            state_in = alu_ge ? S_ACC : S_ABSB;
         end
         S_ABSB: begin
            diff_in  = alu_res[31:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = alu_res[SUM_W-1:0];
            if (idx_ff == last_ff) begin
               state_in = S_DEVCMP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = idx_ff + 1'b1;
               state_in = S_ABSA;
            end
         end
         S_DEVCMP: begin
            if (!alu_ge) begin
               choice_in = newest_ff;
               state_in  = S_CAP;
            end else begin
               state_in  = S_MEANCMP;
            end
         end
         S_MEANCMP: begin
            choice_in = alu_ge ? newest_ff : mean_ff;
            state_in  = S_CAP;
         end
         S_CAP: begin
            state_in = (alu_ge && lag_ff) ? S_CAPDEC : S_CLAMP;
         end
         S_CAPDEC: begin
            cap_in   = alu_ge ? alu_res[31:0] : '0;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = alu_ge ? cap_ff : choice_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         filled_ff    <= '0;
         cap_ff       <= bwe_pkg::ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      newest_idx_ff <= newest_idx_in;
      idx_ff        <= idx_in;
      few_ff        <= few_in;
      bw_ff         <= bw_in;
      lag_ff        <= lag_in;
      limit_ff      <= limit_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      min_ff        <= min_in;
      mean_ff       <= mean_in;
      newest_ff     <= newest_in;
      diff_ff       <= diff_in;
      choice_ff     <= choice_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_speed = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_after_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_CLAMP))
      else $error("response without clamp step");

   a_rsp_under_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chosen_speed <= cap_ff))
      else $error("response above speed cap");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == bwe_pkg::REQ_QUERY)) |=> busy)
      else $error("query transfer did not raise busy");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (filled_ff != CNT_W'(WINDOW))) |=> (filled_ff == $past(filled_ff) + 1'b1))
      else $error("fill count did not advance on sample");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bandwidth_window_estimator. Drives sample and
// query transfers through the start/busy handshake, computes the chosen
// speed for every query from its own copy of the sample ring and speed cap,
// and compares each rsp_valid strobe with the oldest pending prediction.
// Directed checks cover the empty ring, the cap extremes and ring wrap;
// random traffic follows under several sender idling patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int WINDOW = bwe_pkg::DEFAULT_WINDOW;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [31:0] req_sample_speed;
   logic [31:0] req_current_bandwidth;
   logic        req_video_delay;
   logic        rsp_valid;
   logic [31:0] rsp_chosen_speed;

   // predictor state
   logic [31:0] ring_samples [WINDOW];
   int          next_slot;
   int          sample_count;
   logic [31:0] speed_cap;
   logic [31:0] latest_sample;

   logic [31:0] expected_speeds [$];
   logic [31:0] expected_speed;
   int          error_count;
   int          drain_cycles;

   bandwidth_window_estimator #(
      .WINDOW(WINDOW)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_sample_speed     (req_sample_speed),
      .req_current_bandwidth(req_current_bandwidth),
      .req_video_delay      (req_video_delay),
      .rsp_valid            (rsp_valid),
      .rsp_chosen_speed     (rsp_chosen_speed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic void store_sample(logic [31:0] speed);
      ring_samples[next_slot] = speed;
      next_slot = (next_slot + 1) % WINDOW;
      if (sample_count < WINDOW) sample_count++;
      latest_sample = speed;
   endfunction

   function automatic logic [31:0] predict_chosen_speed(logic [31:0] bw, logic lag);
      logic [31:0] choice;
      logic [31:0] lowest;
      logic [31:0] newest;
      logic [63:0] total;
      logic [63:0] mean;
      logic [63:0] spread;
      logic [63:0] value;
      int          newest_idx;
      choice = bwe_pkg::ALL_ONES;
      if (sample_count > 0) begin
         lowest = bwe_pkg::ALL_ONES;
         total  = '0;
         for (int i = 0; i < sample_count; i++) begin
            if (ring_samples[i] < lowest) lowest = ring_samples[i];
            total += {32'd0, ring_samples[i]};
         end
         mean   = total / 64'(sample_count);
         spread = '0;
         for (int i = 0; i < sample_count; i++) begin
            value = {32'd0, ring_samples[i]};
            spread += (value >= mean) ? (value - mean) : (mean - value);
         end
         newest_idx = (next_slot == 0) ? sample_count - 1 : next_slot - 1;
         newest     = ring_samples[newest_idx];
         if (32'(sample_count) < bwe_pkg::MIN_FOR_STATS) begin
            choice = lowest;
         end else if (spread < 64'(bwe_pkg::DEV_LIMIT) * 64'(sample_count)) begin
            choice = newest;
         end else begin
            choice = (mean < {32'd0, newest}) ? mean[31:0] : newest;
         end
         if (newest >= bw && lag) speed_cap = (bw == 32'd0) ? 32'd0 : bw - 32'd1;
      end
      if (choice > speed_cap) choice = speed_cap;
      return choice;
   endfunction

   // one transfer; start stays high so a following call can go back to back
   task automatic issue_request(logic kind, logic [31:0] speed, logic [31:0] bw,
                                logic lag);
      start                 <= 1'b1;
      req_type              <= kind;
      req_sample_speed      <= speed;
      req_current_bandwidth <= bw;
      req_video_delay       <= lag;
      do @(posedge clock); while (busy);
      if (kind == bwe_pkg::REQ_SAMPLE) store_sample(speed);
      else expected_speeds.push_back(predict_chosen_speed(bw, lag));
   endtask

   task automatic pause_sender(int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (idle_pct > 0 && $urandom_range(99) < 4) gap += $urandom_range(1, 130);
      repeat (gap) begin
         start                 <= 1'b0;
         req_type              <= 1'($urandom_range(1));
         req_sample_speed      <= $urandom;
         req_current_bandwidth <= $urandom;
         req_video_delay       <= 1'($urandom_range(1));
         @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_speeds.size() != 0);
   endtask

   function automatic logic [31:0] pick_bandwidth();
      case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3, 4:    return latest_sample;
         5:       return latest_sample + 32'd1;
         6, 7:    return latest_sample - 32'($urandom_range(0, 200000));
         8:       return 32'd0;
         default: return bwe_pkg::ALL_ONES;
      endcase
   endfunction

   task automatic test_empty_ring();
      issue_request(bwe_pkg::REQ_QUERY, $urandom, 32'd0, 1'b1);
      issue_request(bwe_pkg::REQ_QUERY, $urandom, $urandom, 1'b0);
      wait_for_results();
   endtask

   task automatic test_cap_extremes();
      issue_request(bwe_pkg::REQ_SAMPLE, 32'd0, $urandom, 1'b0);
      issue_request(bwe_pkg::REQ_SAMPLE, bwe_pkg::ALL_ONES, $urandom, 1'b1);
      // zero bandwidth under lag: cap saturates at zero
      issue_request(bwe_pkg::REQ_QUERY, $urandom, 32'd0, 1'b1);
      issue_request(bwe_pkg::REQ_SAMPLE, bwe_pkg::ALL_ONES, $urandom, 1'b0);
      // lift the cap to one below its top
      issue_request(bwe_pkg::REQ_QUERY, $urandom, bwe_pkg::ALL_ONES, 1'b1);
      wait_for_results();
   endtask

   task automatic test_ring_wrap();
      repeat (13) issue_request(bwe_pkg::REQ_SAMPLE,
                                32'd1000000 + 32'($urandom_range(0, 50000)),
                                $urandom, 1'b0);
      issue_request(bwe_pkg::REQ_QUERY, $urandom, $urandom, 1'b0);
      repeat (3) issue_request(bwe_pkg::REQ_SAMPLE,
                               32'd1000000 + 32'($urandom_range(0, 50000)),
                               $urandom, 1'b1);
      issue_request(bwe_pkg::REQ_QUERY, $urandom, latest_sample, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_traffic(int idle_pct, int quota);
      int          sent;
      int          burst;
      logic [31:0] base;
      logic [31:0] jitter;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 80) begin
            base   = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 8000000));
            jitter = $urandom_range(0, 600000);
            burst  = $urandom_range(1, 20);
            repeat (burst) begin
               issue_request(bwe_pkg::REQ_SAMPLE, base + 32'($urandom_range(0, jitter)),
                             $urandom, 1'($urandom_range(1)));
               pause_sender(idle_pct);
               sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               issue_request(bwe_pkg::REQ_QUERY, $urandom, pick_bandwidth(),
                             1'($urandom_range(1)));
               pause_sender(idle_pct);
               sent++;
            end
         end else begin
            issue_request(1'($urandom_range(1)), $urandom, $urandom,
                          1'($urandom_range(1)));
            pause_sender(idle_pct);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_speeds.size() == 0) begin
            $error("chosen_speed: expected none, actual %h", rsp_chosen_speed);
            error_count++;
         end else begin
            expected_speed = expected_speeds.pop_front();
            if (rsp_chosen_speed !== expected_speed) begin
               $error("chosen_speed: expected %h, actual %h", expected_speed,
                      rsp_chosen_speed);
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count           = 0;
      next_slot             = 0;
      sample_count          = 0;
      speed_cap             = bwe_pkg::ALL_ONES;
      latest_sample         = '0;
      reset                 <= 1'b1;
      start                 <= 1'b0;
      req_type              <= bwe_pkg::REQ_SAMPLE;
      req_sample_speed      <= '0;
      req_current_bandwidth <= '0;
      req_video_delay       <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_ring();
      test_cap_extremes();
      test_ring_wrap();
      test_random_traffic(0, 170);
      wait_for_results();
      test_random_traffic(56, 170);
      wait_for_results();
      test_random_traffic(14, 170);

      start <= 1'b0;
      drain_cycles = 0;
      while (expected_speeds.size() != 0 && drain_cycles < 4000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (expected_speeds.size() != 0) begin
         $error("chosen_speed: %0d results never arrived", expected_speeds.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
